// ===== rtl/core/rrp_pkg.sv =====
// Shared types, constants and microcode for the rectangle raster painter.
// No dependencies; every other file imports this package.
`default_nettype none

package rrp_pkg;

	// Canvas geometry.
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration register widths and reset values.
	localparam int CFG_W    = 10;
	localparam int DIM_W    = 11;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam logic [CFG_W-1:0] WIDTH_RST  = 10'd1;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 10'd1;
	localparam logic [7:0]       BG_RST     = 8'd32;

	// Item field widths and the fixed-point format.
	localparam int COORD_W = 20;
	localparam int PIX_W   = 9;
	localparam int FRAC    = 8;
	localparam int GW      = 23;
	localparam logic signed [GW-1:0] ONE_Q8 = 23'sd256;

	localparam logic [7:0] KIND_FILLED  = 8'h52;
	localparam logic [7:0] KIND_OUTLINE = 8'h72;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_RECT  = 2'd1,
		ST_OUTSIDE   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_BG     = 2'd2
	} reg_idx_t;

	// Microprogram addresses.
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] PC_IDLE     = 3'd0;
	localparam logic [PC_W-1:0] PC_DISPATCH = 3'd1;
	localparam logic [PC_W-1:0] PC_SCAN     = 3'd2;
	localparam logic [PC_W-1:0] PC_READ     = 3'd3;
	localparam logic [PC_W-1:0] PC_READ_OUT = 3'd4;
	localparam logic [PC_W-1:0] PC_OK       = 3'd5;
	localparam logic [PC_W-1:0] PC_BAD      = 3'd6;

	// Sequencing conditions of a control word.
	typedef enum logic [2:0] {
		C_NEXT       = 3'd0,
		C_JUMP       = 3'd1,
		C_WAIT_START = 3'd2,
		C_WAIT_LAST  = 3'd3,
		C_DISPATCH   = 3'd4
	} cond_t;

	// One control word of the microprogram.
	typedef struct packed {
		logic             clr_pos;
		logic             scan;
		logic             mem_rd;
		logic             emit;
		logic             use_read;
		status_t          status_code;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ctrl_t;

	// Datapath flags that steer the sequencer.
	typedef struct packed {
		logic last_pixel;
		logic draw_ok;
		op_t  op;
	} flags_t;

	// Read-only microprogram.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w             = '0;
		w.status_code = ST_OK;
		w.cond        = C_NEXT;
		w.target      = PC_IDLE;
		unique case (pc)
			PC_IDLE: begin
				w.cond   = C_WAIT_START;
				w.target = PC_DISPATCH;
			end
			PC_DISPATCH: begin
				w.clr_pos = 1'b1;
				w.cond    = C_DISPATCH;
			end
			PC_SCAN: begin
				w.scan   = 1'b1;
				w.cond   = C_WAIT_LAST;
				w.target = PC_OK;
			end
			PC_READ: begin
				w.mem_rd = 1'b1;
				w.cond   = C_NEXT;
			end
			PC_READ_OUT: begin
				w.emit     = 1'b1;
				w.use_read = 1'b1;
				w.cond     = C_JUMP;
			end
			PC_OK: begin
				w.emit = 1'b1;
				w.cond = C_JUMP;
			end
			PC_BAD: begin
				w.emit        = 1'b1;
				w.status_code = ST_BAD_RECT;
				w.cond        = C_JUMP;
			end
			default: begin
				w.cond = C_JUMP;
			end
		endcase
		return w;
	endfunction

	// Entry point of each command.
	function automatic logic [PC_W-1:0] dispatch_pc(input op_t op, input logic ok);
		logic [PC_W-1:0] t;
		t = PC_OK;
		unique case (op)
			OP_CLEAR: t = PC_SCAN;
			OP_DRAW:  t = ok ? PC_SCAN : PC_BAD;
			OP_READ:  t = PC_READ;
			OP_NONE:  t = PC_OK;
			default:  t = PC_OK;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rrp_cfg.sv =====
// Configuration register file of the rectangle raster painter (APB-style port).
// Depends on rrp_pkg for widths, reset values and register indexes.
`default_nettype none

module rrp_cfg
	import rrp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output logic      [DIM_W-1:0]   cw,
	output logic      [DIM_W-1:0]   ch,
	output logic      [7:0]         bg
);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [7:0]       bg_q;
	reg_idx_t         idx;
	logic             wr_en;
	logic [DIM_W-1:0] width_ext;
	logic [DIM_W-1:0] height_ext;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			bg_q     <= BG_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				REG_BG:     bg_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read-back of the raw register values.
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_BG:     prdata = PDATA_W'(bg_q);
			default:    prdata = '0;
		endcase
	end

	// The dimensions in use are saturated to the canvas size, with zero acting as one.
	assign width_ext  = DIM_W'(width_q);
	assign height_ext = DIM_W'(height_q);

	always_comb begin
		if (width_ext == '0)
			cw = DIM_W'(1);
		else if (width_ext > DIM_W'(MAX_WIDTH))
			cw = DIM_W'(MAX_WIDTH);
		else
			cw = width_ext;

		if (height_ext == '0)
			ch = DIM_W'(1);
		else if (height_ext > DIM_W'(MAX_HEIGHT))
			ch = DIM_W'(MAX_HEIGHT);
		else
			ch = height_ext;
	end

	assign bg = bg_q;

endmodule

`default_nettype wire

// ===== rtl/core/rrp_sequencer.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on rrp_pkg for the microprogram and the control word type.
`default_nettype none

module rrp_sequencer
	import rrp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire flags_t flags,
	output ctrl_t       ctrl,
	output logic        busy
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;

	assign ctrl = ucode(pc_q);
	assign busy = (pc_q != PC_IDLE);

	// Next step from the condition field of the current control word.
	always_comb begin
		pc_next = PC_IDLE;
		unique case (ctrl.cond)
			C_NEXT:       pc_next = pc_q + PC_W'(1);
			C_JUMP:       pc_next = ctrl.target;
			C_WAIT_START: pc_next = start ? ctrl.target : pc_q;
			C_WAIT_LAST:  pc_next = flags.last_pixel ? ctrl.target : pc_q;
			C_DISPATCH:   pc_next = dispatch_pc(flags.op, flags.draw_ok);
			default:      pc_next = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= PC_IDLE;
		else
			pc_q <= pc_next;
	end

endmodule

`default_nettype wire

// ===== rtl/core/rrp_datapath.sv =====
// Datapath: item registers, rectangle edge compares, pixel scan counters, the
// canvas memory and the result registers. Depends on rrp_pkg.
`default_nettype none

module rrp_datapath
	import rrp_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire ctrl_t                     ctrl,
	input  wire logic        [1:0]         operation,
	input  wire logic        [7:0]         shape_kind,
	input  wire logic signed [COORD_W-1:0] left_x,
	input  wire logic signed [COORD_W-1:0] top_y,
	input  wire logic signed [COORD_W-1:0] rect_width,
	input  wire logic signed [COORD_W-1:0] rect_height,
	input  wire logic        [7:0]         paint,
	input  wire logic        [PIX_W-1:0]   pixel_x,
	input  wire logic        [PIX_W-1:0]   pixel_y,
	input  wire logic        [DIM_W-1:0]   cw,
	input  wire logic        [DIM_W-1:0]   ch,
	input  wire logic        [7:0]         bg,
	output flags_t                         flags,
	output logic                           done,
	output logic             [1:0]         status,
	output logic             [7:0]         pixel_value
);

	// Item registers.
	op_t                       op_q;
	logic        [7:0]         kind_q;
	logic signed [COORD_W-1:0] w_q;
	logic signed [COORD_W-1:0] h_q;
	logic        [7:0]         paint_q;
	logic        [PIX_W-1:0]   rd_x_q;
	logic        [PIX_W-1:0]   rd_y_q;

	// Rectangle edges in Q.8, and the edges moved one unit inwards.
	logic signed [GW-1:0] left_q;
	logic signed [GW-1:0] top_q;
	logic signed [GW-1:0] right_q;
	logic signed [GW-1:0] bottom_q;
	logic signed [GW-1:0] left_in_q;
	logic signed [GW-1:0] top_in_q;
	logic signed [GW-1:0] right_in_q;
	logic signed [GW-1:0] bottom_in_q;

	// Scan position.
	logic [XW-1:0]     x_q;
	logic [YW-1:0]     y_q;
	logic [ADDR_W-1:0] row_q;

	logic signed [GW-1:0] px;
	logic signed [GW-1:0] py;
	logic                 in_rect;
	logic                 near;
	logic                 hit;
	logic                 last_x;
	logic                 last_y;
	logic                 in_range;

	logic [7:0]        canvas_mem [0:DEPTH-1];
	logic [7:0]        rd_q;
	logic              we;
	logic [7:0]        wd;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;

	logic          done_q;
	status_t       status_q;
	logic [7:0]    value_q;

	// Capture of the item and its edges; right and bottom inner edges are set at dispatch.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(operation);
			kind_q    <= shape_kind;
			w_q       <= rect_width;
			h_q       <= rect_height;
			paint_q   <= paint;
			rd_x_q    <= pixel_x;
			rd_y_q    <= pixel_y;
			left_q    <= GW'(left_x);
			top_q     <= GW'(top_y);
			right_q   <= GW'(left_x) + GW'(rect_width);
			bottom_q  <= GW'(top_y) + GW'(rect_height);
			left_in_q <= GW'(left_x) + ONE_Q8;
			top_in_q  <= GW'(top_y) + ONE_Q8;
		end
		if (ctrl.clr_pos) begin
			right_in_q  <= right_q - ONE_Q8;
			bottom_in_q <= bottom_q - ONE_Q8;
		end
	end

	// Scan counters walk the canvas in use row by row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			row_q <= '0;
		end else if (ctrl.clr_pos) begin
			x_q   <= '0;
			y_q   <= '0;
			row_q <= '0;
		end else if (ctrl.scan) begin
			if (last_x) begin
				x_q   <= '0;
				y_q   <= y_q + YW'(1);
				row_q <= row_q + ADDR_W'(MAX_WIDTH);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	assign last_x = (DIM_W'(x_q) == cw - DIM_W'(1));
	assign last_y = (DIM_W'(y_q) == ch - DIM_W'(1));

	// Pixel coverage: inside the closed rectangle, and near an edge for outlines.
	assign px      = GW'({x_q, {FRAC{1'b0}}});
	assign py      = GW'({y_q, {FRAC{1'b0}}});
	assign in_rect = (px >= left_q) && (px <= right_q) && (py >= top_q) && (py <= bottom_q);
	assign near    = (px < left_in_q) || (px > right_in_q) ||
	                 (py < top_in_q) || (py > bottom_in_q);
	assign hit     = in_rect && ((kind_q == KIND_FILLED) || near);

	// Flags for the sequencer.
	assign flags.last_pixel = last_x && last_y;
	assign flags.draw_ok    = (w_q > 20'sd0) && (h_q > 20'sd0) &&
	                          ((kind_q == KIND_FILLED) || (kind_q == KIND_OUTLINE));
	assign flags.op         = op_q;

	// Canvas write port for clear and draw, read port for pixel reads.
	assign we    = ctrl.scan && ((op_q == OP_CLEAR) || hit);
	assign wd    = (op_q == OP_CLEAR) ? bg : paint_q;
	assign waddr = row_q + ADDR_W'(x_q);

	assign in_range = (DIM_W'(rd_x_q) < cw) && (DIM_W'(rd_y_q) < ch);
	assign raddr    = in_range ?
	                  (ADDR_W'(rd_y_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_x_q)) : '0;

	always_ff @(posedge clk) begin
		if (we)
			canvas_mem[waddr] <= wd;
		if (ctrl.mem_rd)
			rd_q <= canvas_mem[raddr];
	end

	// Result registers: one strobe per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= ctrl.emit;
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			if (ctrl.use_read) begin
				status_q <= in_range ? ST_OK : ST_OUTSIDE;
				value_q  <= in_range ? rd_q : 8'd0;
			end else begin
				status_q <= ctrl.status_code;
				value_q  <= 8'd0;
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign pixel_value = value_q;

endmodule

`default_nettype wire

// ===== rtl/core/rectangle_raster_painter.sv =====
// Rectangle raster painter: a byte canvas with clear, draw-rectangle and read-pixel
// commands. A command is taken when start is high and busy is low; its single result
// appears on status and pixel_value for one cycle with done high, and must be taken
// then, as the block cannot hold it. After dispatch, clear and valid draw sweep the
// canvas in use one pixel per cycle via its one write port, then report; a read does
// a memory read and an output step; an invalid draw or unused command reports
// directly. Canvas contents are undefined after reset until a clear has been run. The
// user must write configuration only while busy is low; the block does not enforce it.
`default_nettype none

module rectangle_raster_painter
	import rrp_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic        [PADDR_W-1:0] paddr,
	input  wire logic        [PDATA_W-1:0] pwdata,
	output logic             [PDATA_W-1:0] prdata,
	output logic                           pready,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic        [1:0]         operation,
	input  wire logic        [7:0]         shape_kind,
	input  wire logic signed [COORD_W-1:0] left_x,
	input  wire logic signed [COORD_W-1:0] top_y,
	input  wire logic signed [COORD_W-1:0] rect_width,
	input  wire logic signed [COORD_W-1:0] rect_height,
	input  wire logic        [7:0]         paint,
	input  wire logic        [PIX_W-1:0]   pixel_x,
	input  wire logic        [PIX_W-1:0]   pixel_y,
	output logic                           done,
	output logic             [1:0]         status,
	output logic             [7:0]         pixel_value
);

	logic             [DIM_W-1:0] cw;
	logic             [DIM_W-1:0] ch;
	logic             [7:0]       bg;
	ctrl_t                        ctrl;
	flags_t                       flags;
	logic                         accept;

	assign accept = start && !busy;

	// Configuration registers.
	rrp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cw      (cw),
		.ch      (ch),
		.bg      (bg)
	);

	// Microcode sequencer.
	rrp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Datapath and canvas.
	rrp_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.ctrl        (ctrl),
		.operation   (operation),
		.shape_kind  (shape_kind),
		.left_x      (left_x),
		.top_y       (top_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.paint       (paint),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.cw          (cw),
		.ch          (ch),
		.bg          (bg),
		.flags       (flags),
		.done        (done),
		.status      (status),
		.pixel_value (pixel_value)
	);

	// A result is delivered only once the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a command is in progress");

	// An accepted item always starts the sequencer.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not start the sequencer");

	// Each item yields one result strobe, never two in a row.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// The canvas is only written while a command is in progress.
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.scan |-> busy)
		else $error("canvas sweep outside a command");

endmodule

`default_nettype wire
